/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bra_pkg.sv */
// Types, widths and constants of the bilinear resize core.
package bra_pkg;

    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int IDX_W    = 6;
    localparam int CHAN_W   = 4;
    localparam int ADDR_W   = ROW_W + COL_W + CHAN_W;
    localparam int SAMPLE_W = 16;
    localparam int Q_W      = 12;
    localparam int DIM_W    = 7;
    localparam int RATIO_W  = 22;
    localparam int FRAC_W   = 16;
    localparam int POS_W    = RATIO_W + Q_W;
    localparam int IP_W     = POS_W - FRAC_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = RATIO_W;

    // Horizontal blend: exact value needs 32 bits, computed at 34.
    localparam int HSUM_W = 2 * (SAMPLE_W + 1);
    localparam int TOP_W  = SAMPLE_W + FRAC_W;
    // Vertical blend: exact value needs 48 bits, computed at 50.
    localparam int VSUM_W = FRAC_W + 1 + TOP_W + 1;
    localparam int TOT_W  = TOP_W + FRAC_W;
    localparam int RND_W  = TOT_W + 1;
    localparam int OUT_SHIFT = 2 * FRAC_W;
    localparam int QV_W      = RND_W - OUT_SHIFT;

    localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(63);
    localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(63);

    localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (OUT_SHIFT - 1);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_RATIO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_COL_RATIO = CFG_IDX_W'(3);

    // Source index pair and weight along one axis.
    typedef struct packed {
        logic [IDX_W-1:0]  base;
        logic [IDX_W-1:0]  next;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOC,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RDW,
        ST_HBL,
        ST_VBL,
        ST_OUT
    } state_t;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [ROW_W-1:0]  row,
        input logic [COL_W-1:0]  col,
        input logic [CHAN_W-1:0] chan
    );
        store_addr = {row, col, chan};
    endfunction

endpackage

/* hw/rtl/bilinear_resize_align_corners_core.sv */
// Bilinear resize core, align-corners, over a 64 x 64 x 16 store of Q8.8 samples.
// Load request: written to the store in the accept cycle; next request can be taken in the following cycle.
// Query request: multiply, locate, four serial reads of the store's single read port plus
// read wait, two blend stages, output (result register loaded), idle; no request is taken
// until idle, and an unaccepted result holds the FSM in output.
// Reset (aresetn low, synchronous): FSM idle, no result held, height/width 1, ratios 0.
module bilinear_resize_align_corners_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic [bra_pkg::ROW_W-1:0]          s_load_row,
    input  logic [bra_pkg::COL_W-1:0]          s_load_col,
    input  logic [bra_pkg::CHAN_W-1:0]         s_load_chan,
    input  logic signed [bra_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [bra_pkg::Q_W-1:0]            s_query_row,
    input  logic [bra_pkg::Q_W-1:0]            s_query_col,
    input  logic [bra_pkg::CHAN_W-1:0]         s_query_chan,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bra_pkg::SAMPLE_W-1:0] m_value,
    output logic [bra_pkg::Q_W-1:0]            m_out_row,
    output logic [bra_pkg::Q_W-1:0]            m_out_col,
    output logic [bra_pkg::CHAN_W-1:0]         m_out_chan,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bra_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bra_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   in_height_reg;
    logic [DIM_W-1:0]   in_width_reg;
    logic [RATIO_W-1:0] row_ratio_reg;
    logic [RATIO_W-1:0] col_ratio_reg;

    // Always able to take a write; software must only write while idle; the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_height_reg <= DIM_W'(1);
            in_width_reg  <= DIM_W'(1);
            row_ratio_reg <= '0;
            col_ratio_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_IN_HEIGHT: in_height_reg <= cfg_data[DIM_W-1:0];
                CFG_IN_WIDTH:  in_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_ROW_RATIO: row_ratio_reg <= cfg_data[RATIO_W-1:0];
                CFG_COL_RATIO: col_ratio_reg <= cfg_data[RATIO_W-1:0];
                default: ; // unknown index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic s_accept;
    logic is_query;
    logic rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic out_load;

    assign s_accept = s_valid && s_ready;
    assign is_query = (s_op == OP_QUERY);

    // Query registers, captured at accept
    logic [Q_W-1:0]    q_row_reg;
    logic [Q_W-1:0]    q_col_reg;
    logic [CHAN_W-1:0] q_chan_reg;

    // Ratio products (unsigned Q.16 source positions)
    logic [POS_W-1:0] row_pos_reg;
    logic [POS_W-1:0] col_pos_reg;

    // Axis results from the locate units
    axis_t row_loc;
    axis_t col_loc;
    axis_t row_loc_reg;
    axis_t col_loc_reg;

    // Four neighbours: a=(r0,c0) b=(r0,c1) c=(r1,c0) d=(r1,c1)
    logic signed [SAMPLE_W-1:0] samp_a_reg;
    logic signed [SAMPLE_W-1:0] samp_b_reg;
    logic signed [SAMPLE_W-1:0] samp_c_reg;
    logic signed [SAMPLE_W-1:0] samp_d_reg;

    logic signed [TOP_W-1:0] top_reg;
    logic signed [TOP_W-1:0] bot_reg;
    logic signed [TOT_W-1:0] total_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && is_query) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_LOC;
            ST_LOC: state_next = ST_RD0;
            ST_RD0: state_next = ST_RD1;
            ST_RD1: state_next = ST_RD2;
            ST_RD2: state_next = ST_RD3;
            ST_RD3: state_next = ST_RDW;
            ST_RDW: state_next = ST_HBL;
            ST_HBL: state_next = ST_VBL;
            ST_VBL: state_next = ST_OUT;
            ST_OUT: begin
                // wait only while the result register is still full
                if (!m_valid || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine: request ready, store read port, result load
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_RD0: begin
                rd_en   = 1'b1;
                rd_addr = store_addr(row_loc_reg.base, col_loc_reg.base, q_chan_reg);
            end
            ST_RD1: begin
                rd_en   = 1'b1;
                rd_addr = store_addr(row_loc_reg.base, col_loc_reg.next, q_chan_reg);
            end
            ST_RD2: begin
                rd_en   = 1'b1;
                rd_addr = store_addr(row_loc_reg.next, col_loc_reg.base, q_chan_reg);
            end
            ST_RD3: begin
                rd_en   = 1'b1;
                rd_addr = store_addr(row_loc_reg.next, col_loc_reg.next, q_chan_reg);
            end
            ST_OUT: out_load = !m_valid || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Frame store: one write port (loads), one registered read port.
    // Loads are only taken in idle, so reads of a query never meet a write.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] frame_store [2**ADDR_W];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (s_accept && !is_query) begin
            frame_store[store_addr(s_load_row, s_load_col, s_load_chan)] <= s_sample;
        end
        if (rd_en) begin
            rd_data_reg <= frame_store[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Position and weights
    // ------------------------------------------------------------------
    bra_axis_locate u_row_loc (
        .pos      (row_pos_reg),
        .dim      (in_height_reg),
        .max_last (ROW_LAST),
        .loc      (row_loc)
    );

    bra_axis_locate u_col_loc (
        .pos      (col_pos_reg),
        .dim      (in_width_reg),
        .max_last (COL_LAST),
        .loc      (col_loc)
    );

    // ------------------------------------------------------------------
    // Blend arithmetic
    //   top = a*2^16 + fw*(b-a)        (same as (1-fw)*a + fw*b, exact)
    //   bot = c*2^16 + fw*(d-c)
    //   tot = top*2^16 + fh*(bot-top)
    //   value = floor((tot + 2^31) / 2^32), saturated
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W:0]   diff_ab;
    logic signed [SAMPLE_W:0]   diff_cd;
    logic signed [FRAC_W:0]     fw_s;
    logic signed [FRAC_W:0]     fh_s;
    logic signed [HSUM_W-1:0]   top_full;
    logic signed [HSUM_W-1:0]   bot_full;
    logic signed [TOP_W:0]      diff_tb;
    logic signed [VSUM_W-1:0]   total_full;
    logic signed [RND_W-1:0]    rounded;
    logic signed [QV_W-1:0]     q_val;
    logic signed [SAMPLE_W-1:0] value_sat;

    always_comb begin
        fw_s    = $signed({1'b0, col_loc_reg.frac});
        fh_s    = $signed({1'b0, row_loc_reg.frac});
        diff_ab = (SAMPLE_W+1)'(samp_b_reg) - (SAMPLE_W+1)'(samp_a_reg);
        diff_cd = (SAMPLE_W+1)'(samp_d_reg) - (SAMPLE_W+1)'(samp_c_reg);

        top_full = (HSUM_W'(samp_a_reg) <<< FRAC_W) + HSUM_W'(fw_s * diff_ab);
        bot_full = (HSUM_W'(samp_c_reg) <<< FRAC_W) + HSUM_W'(fw_s * diff_cd);

        diff_tb    = (TOP_W+1)'(bot_reg) - (TOP_W+1)'(top_reg);
        total_full = (VSUM_W'(top_reg) <<< FRAC_W) + VSUM_W'(fh_s * diff_tb);

        // round half up, then floor by arithmetic shift
        rounded = RND_W'(total_reg) + $signed(ROUND_HALF);
        q_val   = rounded[RND_W-1:OUT_SHIFT];
        if (q_val[QV_W-1] != q_val[QV_W-2]) begin
            value_sat = q_val[QV_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            value_sat = q_val[SAMPLE_W-1:0];
        end
    end

    // Datapath registers, stepped by state
    always_ff @(posedge aclk) begin
        if (s_accept && is_query) begin
            q_row_reg  <= s_query_row;
            q_col_reg  <= s_query_col;
            q_chan_reg <= s_query_chan;
        end
        if (state_reg == ST_MUL) begin
            row_pos_reg <= POS_W'(row_ratio_reg) * POS_W'(q_row_reg);
            col_pos_reg <= POS_W'(col_ratio_reg) * POS_W'(q_col_reg);
        end
        if (state_reg == ST_LOC) begin
            row_loc_reg <= row_loc;
            col_loc_reg <= col_loc;
        end
        // read data is registered, so each sample is taken in the state after its address
        if (state_reg == ST_RD1) samp_a_reg <= rd_data_reg;
        if (state_reg == ST_RD2) samp_b_reg <= rd_data_reg;
        if (state_reg == ST_RD3) samp_c_reg <= rd_data_reg;
        if (state_reg == ST_RDW) samp_d_reg <= rd_data_reg;
        if (state_reg == ST_HBL) begin
            top_reg <= top_full[TOP_W-1:0];
            bot_reg <= bot_full[TOP_W-1:0];
        end
        if (state_reg == ST_VBL) begin
            total_reg <= total_full[TOT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result register: parts the FSM from the consumer
    // ------------------------------------------------------------------
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_value_reg;
    logic [Q_W-1:0]             m_out_row_reg;
    logic [Q_W-1:0]             m_out_col_reg;
    logic [CHAN_W-1:0]          m_out_chan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg    <= value_sat;
            m_out_row_reg  <= q_row_reg;
            m_out_col_reg  <= q_col_reg;
            m_out_chan_reg <= q_chan_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_value    = m_value_reg;
    assign m_out_row  = m_out_row_reg;
    assign m_out_col  = m_out_col_reg;
    assign m_out_chan = m_out_chan_reg;

endmodule

/* hw/rtl/bra_axis_locate.sv */
// Source index, neighbour index and weight along one axis, with edge clamping.
module bra_axis_locate (
    input  logic [bra_pkg::POS_W-1:0] pos,
    input  logic [bra_pkg::DIM_W-1:0] dim,
    input  logic [bra_pkg::IDX_W-1:0] max_last,
    output bra_pkg::axis_t            loc
);
    import bra_pkg::*;

    logic [DIM_W-1:0] dim_m1;
    logic [IDX_W-1:0] last;
    logic [IP_W-1:0]  ip;
    logic [IP_W-1:0]  last_ext;

    always_comb begin
        dim_m1 = dim - DIM_W'(1);
        // zero height/width behaves as one, oversize as the store limit
        priority if (dim == '0) begin
            last = '0;
        end else if (dim_m1 > DIM_W'(max_last)) begin
            last = max_last;
        end else begin
            last = dim_m1[IDX_W-1:0];
        end

        ip       = pos[POS_W-1:FRAC_W];
        last_ext = IP_W'(last);

        if (ip >= last_ext) begin
            loc.base = last;
            loc.next = last;
            loc.frac = (ip > last_ext) ? '0 : pos[FRAC_W-1:0];
        end else begin
            loc.base = ip[IDX_W-1:0];
            loc.next = ip[IDX_W-1:0] + IDX_W'(1);
            loc.frac = pos[FRAC_W-1:0];
        end
    end

endmodule

/* hw/rtl/bra_checker.sv */
// Port-level assertions for the bilinear resize core, bound to the top level.
`include "assert_macros.svh"

module bra_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_op,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [bra_pkg::SAMPLE_W-1:0] m_value
);
    import bra_pkg::*;

    logic q_accept;
    logic l_accept;

    assign q_accept = s_valid && s_ready && (s_op == OP_QUERY);
    assign l_accept = s_valid && s_ready && (s_op == OP_LOAD);

    // no result held once reset has been seen
    `ASSERT_CLK_ALWAYS(a_reset_clears_result, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // a stalled result keeps its value
    `ASSERT_CLK(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_value), "stalled result changed")

    // a query occupies the block: no request taken the cycle after it
    `ASSERT_CLK(a_query_busy, aclk, aresetn, q_accept |=> !s_ready, "request taken during a query")

    // loads stream back to back
    `ASSERT_CLK(a_load_no_stall, aclk, aresetn, l_accept |=> s_ready, "load stalled the request channel")

    // a query result is never ready the cycle after its acceptance
    `ASSERT_CLK(a_query_latency, aclk, aresetn, q_accept && !m_valid |=> !m_valid, "result too early")

endmodule

bind bilinear_resize_align_corners_core bra_checker u_bra_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_op    (s_op),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_value (m_value)
);
